>>> hdl/stpa_pkg.sv
// ----------------------------------------------------------------------------
// stpa_pkg
// Shared types and constants for the sparse trivariate polynomial adder.
// ----------------------------------------------------------------------------
package stpa_pkg;

    // Store geometry
    localparam int TERMS = 32;
    localparam int IDX_W = $clog2(TERMS);
    localparam int CNT_W = $clog2(TERMS + 1);

    // Field widths
    localparam int COEF_W = 32;
    localparam int SUM_W  = COEF_W + 1;
    localparam int EXP_W  = 8;
    localparam int KEY_W  = 3 * EXP_W;

    // Input actions
    localparam logic [1:0] ACT_INS_A = 2'd0;
    localparam logic [1:0] ACT_INS_B = 2'd1;
    localparam logic [1:0] ACT_ADD   = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_INS_OK = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_TERM   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // One stored term, key is {x, y, z} so a plain compare is lexicographic
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [COEF_W-1:0] coef;
    } t_term;

    localparam int TERM_W = $bits(t_term);

    // Request to the shared compare / add unit
    typedef struct packed {
        logic              va;
        logic              vb;
        logic [KEY_W-1:0]  key_a;
        logic [KEY_W-1:0]  key_b;
        logic [COEF_W-1:0] coef_a;
        logic [COEF_W-1:0] coef_b;
    } t_unit_req;

    // Response of the shared compare / add unit
    typedef struct packed {
        logic              gt;
        logic              take_a;
        logic              take_b;
        logic [SUM_W-1:0]  sum;
        logic [KEY_W-1:0]  key;
    } t_unit_rsp;

endpackage

>>> hdl/sparse_trivariate_polynomial_adder.sv
// ----------------------------------------------------------------------------
// sparse_trivariate_polynomial_adder
// Two sorted term stores; insert items place terms, add items merge and emit.
// ----------------------------------------------------------------------------
// Insert: scans from the tail, one RAM read and compare per stored term, shifting
//   each smaller term up one slot until the new term lands; a full store answers FULL.
// Add: per output term, read both store RAMs, then compare and add, up to 64 terms;
//   empty stores answer EMPTY.
// One item at a time, taken once the last result is queued; output stalls hold the FSM.
// Reset (synchronous, active low) empties both stores; no clearing pass.
// ----------------------------------------------------------------------------
module sparse_trivariate_polynomial_adder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // coefficient, x_exponent, y_exponent, z_exponent
    input  logic [1:0]  s_axis_tuser,  // action
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // sum_coefficient, sum_x/y/z_exponent, zero pad
    output logic [1:0]  m_axis_tuser,  // status
    output logic        m_axis_tlast   // last
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_INS_RD  = 6'b000010,
        S_INS_CMP = 6'b000100,
        S_MRG_RD  = 6'b001000,
        S_MRG_CMP = 6'b010000,
        S_EMIT    = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_sel_b, n_sel_b;
    logic [stpa_pkg::COEF_W-1:0]     r_coef, n_coef;
    logic [stpa_pkg::KEY_W-1:0]      r_key, n_key;
    logic [stpa_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic [stpa_pkg::CNT_W-1:0]      r_ia, n_ia;
    logic [stpa_pkg::CNT_W-1:0]      r_ib, n_ib;
    logic [stpa_pkg::CNT_W-1:0]      r_cnt_a, n_cnt_a;
    logic [stpa_pkg::CNT_W-1:0]      r_cnt_b, n_cnt_b;
    logic [1:0]                      r_status, n_status;
    logic                            r_out_valid, n_out_valid;
    logic [1:0]                      r_out_status, n_out_status;
    logic [stpa_pkg::SUM_W-1:0]      r_out_coef, n_out_coef;
    logic [stpa_pkg::KEY_W-1:0]      r_out_key, n_out_key;
    logic                            r_out_last, n_out_last;

    logic                            w_in_acc;
    logic                            w_out_free;
    logic [stpa_pkg::CNT_W-1:0]      w_ia_next;
    logic [stpa_pkg::CNT_W-1:0]      w_ib_next;
    logic                            w_last;
    logic [stpa_pkg::CNT_W-1:0]      w_idx_dec;

    logic                            w_we_a, w_we_b, w_re;
    logic [stpa_pkg::IDX_W-1:0]      w_waddr;
    stpa_pkg::t_term                 w_wdata;
    logic [stpa_pkg::IDX_W-1:0]      w_raddr_a, w_raddr_b;
    stpa_pkg::t_term                 w_rd_a, w_rd_b, w_rd_sel;
    stpa_pkg::t_term                 w_new_term;

    stpa_pkg::t_unit_req             w_req;
    stpa_pkg::t_unit_rsp             w_rsp;

    // Term stores
    stpa_ram #(.WIDTH(stpa_pkg::TERM_W), .DEPTH(stpa_pkg::TERMS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rd_a)
    );

    stpa_ram #(.WIDTH(stpa_pkg::TERM_W), .DEPTH(stpa_pkg::TERMS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rd_b)
    );

    // Shared compare / add unit
    stpa_unit u_unit (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // Handshake helpers
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_rd_sel   = r_sel_b ? w_rd_b : w_rd_a;
    assign w_idx_dec  = r_idx - stpa_pkg::CNT_W'(1);
    assign w_new_term = '{key: r_key, coef: r_coef};

    // Unit operands: insert compares the new key against a stored one; merge compares the heads of both stores
    always_comb begin
        if (r_state == S_INS_CMP) begin
            w_req = '{va: 1'b1, vb: 1'b1, key_a: r_key, key_b: w_rd_sel.key,
                      coef_a: r_coef, coef_b: w_rd_sel.coef};
        end else begin
            w_req = '{va: (r_ia < r_cnt_a), vb: (r_ib < r_cnt_b),
                      key_a: w_rd_a.key, key_b: w_rd_b.key,
                      coef_a: w_rd_a.coef, coef_b: w_rd_b.coef};
        end
    end

    // Merge advance and end-of-run detection
    assign w_ia_next = r_ia + stpa_pkg::CNT_W'(w_rsp.take_a);
    assign w_ib_next = r_ib + stpa_pkg::CNT_W'(w_rsp.take_b);
    assign w_last    = (w_ia_next >= r_cnt_a) && (w_ib_next >= r_cnt_b);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_sel_b      = r_sel_b;
        n_coef       = r_coef;
        n_key        = r_key;
        n_idx        = r_idx;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_coef   = r_out_coef;
        n_out_key    = r_out_key;
        n_out_last   = r_out_last;
        w_we_a       = 1'b0;
        w_we_b       = 1'b0;
        w_re         = 1'b0;
        w_waddr      = r_idx[stpa_pkg::IDX_W-1:0];
        w_wdata      = w_new_term;
        w_raddr_a    = w_idx_dec[stpa_pkg::IDX_W-1:0];
        w_raddr_b    = w_idx_dec[stpa_pkg::IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_coef  = s_axis_tdata[31:0];
                    n_key   = {s_axis_tdata[39:32], s_axis_tdata[47:40], s_axis_tdata[55:48]};
                    n_sel_b = (s_axis_tuser == stpa_pkg::ACT_INS_B);
                    n_ia    = '0;
                    n_ib    = '0;
                    unique case (s_axis_tuser) inside
                        stpa_pkg::ACT_INS_A, stpa_pkg::ACT_INS_B: begin
                            n_idx = (s_axis_tuser == stpa_pkg::ACT_INS_B) ? r_cnt_b : r_cnt_a;
                            if (n_idx >= stpa_pkg::CNT_W'(stpa_pkg::TERMS)) begin
                                n_status = stpa_pkg::ST_FULL;
                                n_state  = S_EMIT;
                            end else begin
                                n_state  = S_INS_RD;
                            end
                        end
                        stpa_pkg::ACT_ADD: begin
                            if (r_cnt_a == '0 && r_cnt_b == '0) begin
                                n_status = stpa_pkg::ST_EMPTY;
                                n_state  = S_EMIT;
                            end else begin
                                n_state  = S_MRG_RD;
                            end
                        end
                        default: begin
                            // drop the item, nothing to report
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_RD: begin
                if (r_idx == '0) begin
                    // slot found at the head of the store
                    w_we_a   = !r_sel_b;
                    w_we_b   = r_sel_b;
                    n_cnt_a  = r_sel_b ? r_cnt_a : r_cnt_a + stpa_pkg::CNT_W'(1);
                    n_cnt_b  = r_sel_b ? r_cnt_b + stpa_pkg::CNT_W'(1) : r_cnt_b;
                    n_status = stpa_pkg::ST_INS_OK;
                    n_state  = S_EMIT;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                w_we_a = !r_sel_b;
                w_we_b = r_sel_b;
                if (w_rsp.gt) begin
                    // shift the smaller stored term up one slot
                    w_wdata = w_rd_sel;
                    n_idx   = w_idx_dec;
                    n_state = S_INS_RD;
                end else begin
                    n_cnt_a  = r_sel_b ? r_cnt_a : r_cnt_a + stpa_pkg::CNT_W'(1);
                    n_cnt_b  = r_sel_b ? r_cnt_b + stpa_pkg::CNT_W'(1) : r_cnt_b;
                    n_status = stpa_pkg::ST_INS_OK;
                    n_state  = S_EMIT;
                end
            end

            S_MRG_RD: begin
                w_re      = 1'b1;
                w_raddr_a = r_ia[stpa_pkg::IDX_W-1:0];
                w_raddr_b = r_ib[stpa_pkg::IDX_W-1:0];
                n_state   = S_MRG_CMP;
            end

            S_MRG_CMP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = stpa_pkg::ST_TERM;
                    n_out_coef   = w_rsp.sum;
                    n_out_key    = w_rsp.key;
                    n_out_last   = w_last;
                    n_ia         = w_ia_next;
                    n_ib         = w_ib_next;
                    n_state      = w_last ? S_IDLE : S_MRG_RD;
                end
            end

            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_coef   = '0;
                    n_out_key    = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_sel_b      <= n_sel_b;
        r_coef       <= n_coef;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_ia         <= n_ia;
        r_ib         <= n_ib;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_coef   <= n_out_coef;
        r_out_key    <= n_out_key;
        r_out_last   <= n_out_last;
    end

    // Output item
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {7'd0,
                            r_out_key[7:0],
                            r_out_key[15:8],
                            r_out_key[23:16],
                            r_out_coef};

    // Stores never hold more terms than they have room for
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= stpa_pkg::CNT_W'(stpa_pkg::TERMS)) &&
        (r_cnt_b <= stpa_pkg::CNT_W'(stpa_pkg::TERMS)))
        else $error("term count beyond store depth");

    // Counts change only while an insert is in progress
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INS_RD && r_state != S_INS_CMP) |=>
        ($stable(r_cnt_a) && $stable(r_cnt_b)))
        else $error("term count changed outside an insert");

    // Merge pointers stay within the stores
    a_mrg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRG_RD || r_state == S_MRG_CMP) |->
        ((r_ia <= r_cnt_a) && (r_ib <= r_cnt_b) &&
         ((r_ia < r_cnt_a) || (r_ib < r_cnt_b))))
        else $error("merge pointer out of range");

    // A merge term marked last returns the sequencer to idle
    a_mrg_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRG_CMP && w_out_free && w_last) |=> (r_state == S_IDLE))
        else $error("merge did not finish on its last term");

endmodule

>>> hdl/stpa_ram.sv
// ----------------------------------------------------------------------------
// stpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, hold data when not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/stpa_unit.sv
// ----------------------------------------------------------------------------
// stpa_unit
// Shared key compare and coefficient adder, used by both insert and merge.
// ----------------------------------------------------------------------------
module stpa_unit (
    input  stpa_pkg::t_unit_req i_req,
    output stpa_pkg::t_unit_rsp o_rsp
);

    logic                       w_gt;
    logic                       w_take_a;
    logic                       w_take_b;
    logic [stpa_pkg::SUM_W-1:0] w_op_a;
    logic [stpa_pkg::SUM_W-1:0] w_op_b;

    // Compare keys, x exponent most significant
    assign w_gt = i_req.key_a > i_req.key_b;

    // Pick the side(s) that supply the next term; equal keys take both
    assign w_take_a = i_req.va && (!i_req.vb || w_gt || (i_req.key_a == i_req.key_b));
    assign w_take_b = i_req.vb && (!i_req.va || !w_gt);

    // Sign-extend and gate the operands
    assign w_op_a = w_take_a ? {i_req.coef_a[stpa_pkg::COEF_W-1], i_req.coef_a}
                             : '0;
    assign w_op_b = w_take_b ? {i_req.coef_b[stpa_pkg::COEF_W-1], i_req.coef_b}
                             : '0;

    assign o_rsp.gt     = w_gt;
    assign o_rsp.take_a = w_take_a;
    assign o_rsp.take_b = w_take_b;
    assign o_rsp.sum    = w_op_a + w_op_b;
    assign o_rsp.key    = w_take_a ? i_req.key_a : i_req.key_b;

endmodule
